// ===== hw/rtl/gavg3_pkg.sv =====
package gavg3_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int PEND_BITS = COL_BITS + 2;
   localparam int ROW_BITS = 16;
   localparam int FRAME_WIDTH_BITS = 12;
   localparam int FRAME_HEIGHT_BITS = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [FRAME_WIDTH_BITS-1:0] RESET_FRAME_WIDTH = 12'd640;
   localparam logic [FRAME_HEIGHT_BITS-1:0] RESET_FRAME_HEIGHT = 16'd480;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // floor(s/3) equals (s*683)>>11 for every s below 2048.
   localparam logic [9:0] GRAY_RECIP = 10'd683;
   localparam int GRAY_SHIFT = 11;

   localparam int SLOT_COUNT = 3;
   localparam logic [1:0] SLOT_LAST = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       action;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered_value;
      logic       end_of_row;
      logic       end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic                 clear;
      logic                 single_col;
      logic                 single_row;
      logic [COL_BITS-1:0]  last_col;
      logic [ROW_BITS-1:0]  last_row;
      logic [PEND_BITS-1:0] pend_limit;
   } frame_cfg_type;

   typedef struct packed {
      logic [2:0][2:0][7:0] pix;
      logic                 end_of_row;
      logic                 end_of_frame;
   } window_type;

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      return (s == SLOT_LAST) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      return (s == 2'd0) ? SLOT_LAST : s - 2'd1;
   endfunction

endpackage

// ===== hw/rtl/gavg3_front.sv =====
module gavg3_front import gavg3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  frame_cfg_type         cfg,
   input  logic                  req_valid,
   input  req_type               req,
   output logic                  req_stall,
   input  logic [COUNT_BITS-1:0] queue_count,
   output logic                  push,
   output window_type            push_data
);

   logic [COL_BITS-1:0]  in_col_ff, in_col_in;
   logic [ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [1:0]           in_slot_ff, in_slot_in;
   logic                 done_ff, done_in;
   logic [COL_BITS-1:0]  out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]  out_row_ff, out_row_in;
   logic [1:0]           out_slot_ff, out_slot_in;
   logic [PEND_BITS-1:0] pend_ff, pend_in;

   logic                 accept, is_pix, col_wrap, last_pix, complete_after, emit;
   logic                 out_eor, out_eof;
   logic [PEND_BITS-1:0] pend_after;
   logic [9:0]           pix_sum;
   logic [19:0]          gray_prod;
   logic [7:0]           gray;
   logic [ROW_BITS-1:0]  row_sel [3];
   logic [1:0]           slot_sel [3];
   logic [COL_BITS-1:0]  col_a, col_b;
   logic [2:0]           byp_a, byp_b;

   logic [7:0]           rd_a [SLOT_COUNT];
   logic [7:0]           rd_b [SLOT_COUNT];

   logic                 s1_valid_ff;
   logic [7:0]           s1_gray_ff;
   logic [1:0]           s1_slot_ff [3];
   logic [2:0]           s1_byp_a_ff, s1_byp_b_ff;
   logic                 s1_first_ff, s1_last_ff, s1_eor_ff, s1_eof_ff;
   logic [7:0]           held_ff [3];
   logic [7:0]           val_a [3];
   logic [7:0]           val_b [3];

   assign req_stall = ({1'b0, queue_count} + (COUNT_BITS + 1)'(s1_valid_ff))
                      >= (COUNT_BITS + 1)'(QUEUE_DEPTH);
   assign accept = req_valid && !req_stall;
   assign is_pix = accept && (req.action == ACTION_PIXEL) && !done_ff;

   assign pix_sum = 10'(req.red) + 10'(req.green) + 10'(req.blue);
   assign gray_prod = pix_sum * GRAY_RECIP;
   assign gray = gray_prod[GRAY_SHIFT +: 8];

   assign col_wrap = (in_col_ff == cfg.last_col);
   assign last_pix = is_pix && col_wrap && (in_row_ff == cfg.last_row);
   assign complete_after = done_ff || last_pix;
   assign pend_after = pend_ff + PEND_BITS'(is_pix);
   assign emit = accept && ((complete_after && (pend_after != '0))
                            || (pend_after >= cfg.pend_limit));
   assign out_eor = (out_col_ff == cfg.last_col);
   assign out_eof = out_eor && (out_row_ff == cfg.last_row);

   always_comb begin
      row_sel[1] = out_row_ff;
      slot_sel[1] = out_slot_ff;
      if (cfg.single_row) begin
         row_sel[0] = out_row_ff;
         slot_sel[0] = out_slot_ff;
         row_sel[2] = out_row_ff;
         slot_sel[2] = out_slot_ff;
      end else begin
         if (out_row_ff == '0) begin
            row_sel[0] = out_row_ff + 16'd1;
            slot_sel[0] = slot_next(out_slot_ff);
         end else begin
            row_sel[0] = out_row_ff - 16'd1;
            slot_sel[0] = slot_prev(out_slot_ff);
         end
         if (out_row_ff == cfg.last_row) begin
            row_sel[2] = out_row_ff - 16'd1;
            slot_sel[2] = slot_prev(out_slot_ff);
         end else begin
            row_sel[2] = out_row_ff + 16'd1;
            slot_sel[2] = slot_next(out_slot_ff);
         end
      end
   end

   assign col_a = out_col_ff;
   assign col_b = out_col_ff + COL_BITS'(1);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         byp_a[k] = is_pix && (row_sel[k] == in_row_ff) && (col_a == in_col_ff);
         byp_b[k] = is_pix && (row_sel[k] == in_row_ff) && (col_b == in_col_ff);
      end
   end

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      in_slot_in = in_slot_ff;
      done_in = done_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_slot_in = out_slot_ff;
      pend_in = pend_ff;
      if (cfg.clear || (emit && out_eof)) begin
         in_col_in = '0;
         in_row_in = '0;
         in_slot_in = '0;
         done_in = 1'b0;
         out_col_in = '0;
         out_row_in = '0;
         out_slot_in = '0;
         pend_in = '0;
      end else if (accept) begin
         if (is_pix) begin
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 16'd1;
               in_slot_in = slot_next(in_slot_ff);
            end else begin
               in_col_in = in_col_ff + COL_BITS'(1);
            end
         end
         if (last_pix) begin
            done_in = 1'b1;
         end
         if (emit) begin
            if (out_eor) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 16'd1;
               out_slot_in = slot_next(out_slot_ff);
            end else begin
               out_col_in = out_col_ff + COL_BITS'(1);
            end
         end
         pend_in = pend_after - PEND_BITS'(emit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_slot_ff <= '0;
         done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_slot_ff <= '0;
         pend_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         in_slot_ff <= in_slot_in;
         done_ff <= done_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_slot_ff <= out_slot_in;
         pend_ff <= pend_in;
         s1_valid_ff <= emit;
      end
   end

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_store
      logic [7:0] row_mem [MAX_WIDTH];
      logic [7:0] rd_a_ff, rd_b_ff;

      always_ff @(posedge clock) begin
         if (is_pix && (in_slot_ff == 2'(s))) begin
            row_mem[in_col_ff] <= gray;
         end
         rd_a_ff <= row_mem[col_a];
         rd_b_ff <= row_mem[col_b];
      end

      assign rd_a[s] = rd_a_ff;
      assign rd_b[s] = rd_b_ff;
   end

   always_ff @(posedge clock) begin
      s1_gray_ff <= gray;
      s1_byp_a_ff <= byp_a;
      s1_byp_b_ff <= byp_b;
      s1_first_ff <= (out_col_ff == '0);
      s1_last_ff <= out_eor;
      s1_eor_ff <= out_eor;
      s1_eof_ff <= out_eof;
      for (int k = 0; k < 3; k++) begin
         s1_slot_ff[k] <= slot_sel[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         val_a[k] = s1_byp_a_ff[k] ? s1_gray_ff : rd_a[s1_slot_ff[k]];
         val_b[k] = s1_byp_b_ff[k] ? s1_gray_ff : rd_b[s1_slot_ff[k]];
      end
   end

   always_comb begin
      push = s1_valid_ff;
      push_data.end_of_row = s1_eor_ff;
      push_data.end_of_frame = s1_eof_ff;
      for (int k = 0; k < 3; k++) begin
         push_data.pix[k][1] = val_a[k];
         if (cfg.single_col) begin
            push_data.pix[k][0] = val_a[k];
            push_data.pix[k][2] = val_a[k];
         end else if (s1_first_ff) begin
            push_data.pix[k][0] = val_b[k];
            push_data.pix[k][2] = val_b[k];
         end else if (s1_last_ff) begin
            push_data.pix[k][0] = held_ff[k];
            push_data.pix[k][2] = held_ff[k];
         end else begin
            push_data.pix[k][0] = held_ff[k];
            push_data.pix[k][2] = val_b[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            held_ff[k] <= val_a[k];
         end
      end
   end

endmodule

// ===== hw/rtl/gavg3_queue.sv =====
module gavg3_queue import gavg3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  window_type            push_data,
   input  logic                  pop,
   output logic                  empty,
   output window_type            head,
   output logic [COUNT_BITS-1:0] count
);

   window_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_BITS-1:0] count_ff;

   assign empty = (count_ff == '0);
   assign head = entry_ff[rd_ptr_ff];
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         count_ff <= count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/gavg3_back.sv =====
module gavg3_back import gavg3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  window_type head,
   output logic       pop,
   output logic       rsp_valid,
   output rsp_type    rsp,
   input  logic       rsp_stall
);

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [10:0] mid_sum, corner_twice;
   logic [9:0]  edge_sum, corner_sum;
   logic [12:0] acc;
   logic [7:0]  sat;

   assign pop = !empty && (!rsp_valid_ff || !rsp_stall);

   assign edge_sum = 10'(head.pix[0][1]) + 10'(head.pix[1][0])
                   + 10'(head.pix[1][2]) + 10'(head.pix[2][1]);
   assign corner_sum = 10'(head.pix[0][0]) + 10'(head.pix[0][2])
                     + 10'(head.pix[2][0]) + 10'(head.pix[2][2]);
   assign mid_sum = 11'({head.pix[1][1], 2'b00}) + 11'(edge_sum);
   assign corner_twice = {corner_sum, 1'b0};
   assign acc = 13'(mid_sum) - 13'(corner_twice);

   always_comb begin
      if (acc[12]) begin
         sat = 8'd0;
      end else if (acc[11:8] != 4'd0) begin
         sat = 8'd255;
      end else begin
         sat = acc[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff.filtered_value <= sat;
         rsp_ff.end_of_row <= head.end_of_row;
         rsp_ff.end_of_frame <= head.end_of_frame;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// ===== hw/rtl/gray_average_3x3_line_filter.sv =====
// Takes one RGB pixel item per clock in raster order, converts it to gray and
// returns the saturated 3x3 filter result of each position, with reflected
// borders. A result follows W+1 pixel items after its position (W is the row
// width); flush items drain the last W+1 results of a frame. Input items are
// taken every cycle as long as the four-entry window queue in front of the
// output register has room, so the rate is one item per cycle with the
// output side free and input stalls only while results wait there. The user
// must set the frame size through the register port while the block is idle;
// the block does not enforce it. A size register write restarts the frame.
module gray_average_3x3_line_filter import gavg3_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  req_type                   req,
   output logic                      req_stall,
   output logic                      rsp_valid,
   output rsp_type                   rsp,
   input  logic                      rsp_stall,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [FRAME_WIDTH_BITS-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_BITS-1:0] frame_height_ff;
   frame_cfg_type                cfg;
   int unsigned                  width_eff;
   logic                         csr_write;

   logic                         push, pop, q_empty;
   window_type                   push_data, q_head;
   logic [COUNT_BITS-1:0]        q_count;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_write) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            frame_width_ff <= csr_data[FRAME_WIDTH_BITS-1:0];
         end
         if (csr_index == REG_FRAME_HEIGHT) begin
            frame_height_ff <= csr_data[FRAME_HEIGHT_BITS-1:0];
         end
      end
   end

   always_comb begin
      width_eff = int'(frame_width_ff);
      if (width_eff < 1) begin
         width_eff = 1;
      end
      if (width_eff > MAX_WIDTH) begin
         width_eff = MAX_WIDTH;
      end
      cfg.clear = csr_write && ((csr_index == REG_FRAME_WIDTH)
                                || (csr_index == REG_FRAME_HEIGHT));
      cfg.single_col = (width_eff == 1);
      cfg.last_col = COL_BITS'(width_eff - 1);
      cfg.pend_limit = PEND_BITS'(width_eff + 2);
      cfg.single_row = (frame_height_ff <= 16'd1);
      cfg.last_row = cfg.single_row ? '0 : frame_height_ff - 16'd1;
   end

   gavg3_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req         (req),
      .req_stall   (req_stall),
      .queue_count (q_count),
      .push        (push),
      .push_data   (push_data)
   );

   gavg3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .empty     (q_empty),
      .head      (q_head),
      .count     (q_count)
   );

   gavg3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

endmodule

// ===== hw/rtl/gavg3_checker.sv =====
module gavg3_checker import gavg3_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input req_type req,
   input logic    req_stall,
   input logic    rsp_valid,
   input rsp_type rsp,
   input logic    rsp_stall,
   input logic    csr_valid,
   input logic    csr_ready
);

   // Reset empties the whole pipeline, so input is open and no result shows.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   a_frame_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp.end_of_frame || rsp.end_of_row)
      else $error("frame end without row end");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req))
      else $error("stalled input item changed");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind gray_average_3x3_line_filter gavg3_checker u_gavg3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req       (req),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp       (rsp),
   .rsp_stall (rsp_stall),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

// ===== dv/gray_filter_checker.sv =====
module gray_filter_checker import gavg3_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  req_type                   req,
   input  logic                      req_stall,
   input  logic                      rsp_valid,
   input  rsp_type                   rsp,
   input  logic                      rsp_stall,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        failures,
   output int                        outstanding,
   output int                        results_checked
);

   logic [FRAME_WIDTH_BITS-1:0]  width_reg;
   logic [FRAME_HEIGHT_BITS-1:0] height_reg;
   logic [7:0]                   gray_rows [3][MAX_WIDTH];
   int unsigned                  in_col, in_row, out_col, out_row;
   rsp_type                      expected_results [$];

   assign outstanding = expected_results.size();

   function automatic int unsigned mirror(int pos, int unsigned n);
      if (n <= 1) return 0;
      if (pos < 0) return 1;
      if (pos >= int'(n)) return n - 2;
      return pos;
   endfunction

   task automatic predict_pixel(req_type it);
      int unsigned w, h, next_col, next_row, in_count, out_idx, pending;
      int unsigned r, c;
      bit          have_pix, ready;
      logic [7:0]  gray, v;
      int          acc, weight;
      rsp_type     res;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      have_pix = (it.action == ACTION_PIXEL) && (in_row < h);
      gray = 8'((int'(it.red) + int'(it.green) + int'(it.blue)) / 3);
      if (in_col >= w) in_col = 0;
      next_col = in_col;
      next_row = in_row;
      if (have_pix) begin
         next_col++;
         if (next_col >= w) begin
            next_col = 0;
            next_row++;
         end
      end
      in_count = next_row * w + next_col;
      out_idx = out_row * w + out_col;
      pending = (in_count >= out_idx) ? in_count - out_idx : 0;
      ready = (next_row >= h && pending > 0) || pending >= w + 2;
      if (ready) begin
         acc = 0;
         for (int dy = -1; dy <= 1; dy++) begin
            r = mirror(int'(out_row) + dy, h);
            for (int dx = -1; dx <= 1; dx++) begin
               c = mirror(int'(out_col) + dx, w);
               v = (have_pix && r == in_row && c == in_col) ? gray : gray_rows[r % 3][c];
               weight = (dy == 0 && dx == 0) ? 4 : (dy == 0 || dx == 0) ? 1 : -2;
               acc += weight * int'(v);
            end
         end
         res.filtered_value = (acc < 0) ? 8'd0 : (acc > 255) ? 8'd255 : 8'(acc);
         res.end_of_row = (out_col == w - 1);
         res.end_of_frame = (out_col == w - 1) && (out_row == h - 1);
         expected_results.push_back(res);
      end
      if (have_pix) gray_rows[in_row % 3][in_col] = gray;
      in_col = next_col;
      in_row = next_row;
      if (ready) begin
         if (out_col == w - 1 && out_row == h - 1) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
         end else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg <= RESET_FRAME_WIDTH;
         height_reg <= RESET_FRAME_HEIGHT;
         in_col <= 0;
         in_row <= 0;
         out_col <= 0;
         out_row <= 0;
         failures <= 0;
         results_checked <= 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FRAME_WIDTH) width_reg = csr_data[FRAME_WIDTH_BITS-1:0];
            if (csr_index == REG_FRAME_HEIGHT) height_reg = csr_data;
            if (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT) begin
               in_col = 0;
               in_row = 0;
               out_col = 0;
               out_row = 0;
            end
         end
         if (req_valid && !req_stall) predict_pixel(req);
         if (rsp_valid && !rsp_stall) begin
            results_checked <= results_checked + 1;
            if (expected_results.size() == 0) begin
               if (failures < 10) $display("unexpected result %p", rsp);
               failures <= failures + 1;
            end else begin
               if (expected_results[0] !== rsp) begin
                  if (failures < 10)
                     $display("mismatch: expected %p actual %p", expected_results[0], rsp);
                  failures <= failures + 1;
               end
               void'(expected_results.pop_front());
            end
         end
      end
   end

endmodule

// ===== dv/tb_gray_average_3x3_line_filter.sv =====
module tb_gray_average_3x3_line_filter;
   import gavg3_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 20;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   req_type                   req = '0;
   logic                      req_stall;
   logic                      rsp_valid;
   rsp_type                   rsp;
   logic                      rsp_stall = 1'b0;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   int                        failures, outstanding, results_checked;
   int                        cycle_count = 0;
   int                        items_sent = 0;
   int                        frame_settings = 0;
   bit                        sender_calm = 1'b0;
   bit                        receiver_calm = 1'b0;
   bit                        hold_request = 1'b0;

   gray_average_3x3_line_filter DUT (.*);

   gray_filter_checker checker_inst (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_gray_average_3x3_line_filter NOT OK");
         $finish;
      end
   end

   always begin
      int gap;
      @(posedge clock);
      if (!reset) begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            gap = receiver_calm ? 0 : $urandom_range(8);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(req_type it);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic req_type make_pixel(bit extremes);
      req_type it;
      it.action = ACTION_PIXEL;
      if (extremes) begin
         it.red = {8{$urandom_range(1) == 1}};
         it.green = {8{$urandom_range(1) == 1}};
         it.blue = {8{$urandom_range(1) == 1}};
      end else begin
         it.red = 8'($urandom);
         it.green = 8'($urandom);
         it.blue = 8'($urandom);
      end
      return it;
   endfunction

   // Writes both size registers while idle, then streams one frame (or part of one).
   task automatic run_frame(int unsigned w_set, int unsigned h_set, int pixels,
                            bit extremes, bit noisy);
      int unsigned w, h;
      int          tail;
      req_type     it;
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(REG_FRAME_WIDTH, {4'($urandom), 12'(w_set)});
      @(posedge clock);
      write_csr(REG_FRAME_HEIGHT, 16'(h_set));
      frame_settings++;
      w = (w_set == 0) ? 1 : (w_set > MAX_WIDTH) ? MAX_WIDTH : w_set;
      h = (h_set == 0) ? 1 : h_set;
      for (int i = 0; i < pixels; i++) begin
         if (noisy && $urandom_range(9) == 0) begin
            it = make_pixel(1'b0);
            it.action = ACTION_FLUSH;
            send_item(it);
         end
         send_item(make_pixel(extremes));
      end
      tail = (pixels >= int'(w * h)) ? w + 1 + $urandom_range(2) : $urandom_range(2);
      for (int i = 0; i < tail; i++) begin
         it = make_pixel(1'b0);
         if (!(noisy && $urandom_range(2) == 0)) it.action = ACTION_FLUSH;
         send_item(it);
      end
   endtask

   initial begin
      int unsigned w, h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_frame(3, 3, 9, 1'b1, 1'b0);
      run_frame(0, 0, 1, 1'b0, 1'b0);
      run_frame(1, 4, 4, 1'b1, 1'b0);
      run_frame(4, 1, 4, 1'b0, 1'b0);
      run_frame(2, 2, 4, 1'b1, 1'b1);
      run_frame(1, 65535, 6, 1'b0, 1'b0);
      sender_calm = 1'b1;
      receiver_calm = 1'b1;
      run_frame(4095, 3, 40, 1'b0, 1'b0);
      run_frame(12, 5, 60, 1'b1, 1'b0);
      sender_calm = 1'b0;
      receiver_calm = 1'b0;

      hold_request = 1'b1;
      run_frame(8, 6, 48, 1'b0, 1'b0);

      while (items_sent < 600) begin
         w = ($urandom_range(4) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
         h = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
         sender_calm = ($urandom_range(4) == 0);
         receiver_calm = ($urandom_range(4) == 0);
         run_frame(w, h, (h == 0 ? 1 : h) * (w == 0 ? 1 : w), $urandom_range(5) == 0,
                   $urandom_range(3) == 0);
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items over %0d frame sizes, checked %0d filter results.",
               items_sent, frame_settings, results_checked);
      $display("Sizes ranged from 1x1 to rows past the width limit, with flush noise and an output hold.");
      if (failures == 0) begin
         $display("tb_gray_average_3x3_line_filter OK");
      end else begin
         $display("tb_gray_average_3x3_line_filter NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/gavg3_pkg.sv
hw/rtl/gavg3_front.sv
hw/rtl/gavg3_queue.sv
hw/rtl/gavg3_back.sv
hw/rtl/gray_average_3x3_line_filter.sv
hw/rtl/gavg3_checker.sv
dv/gray_filter_checker.sv
dv/tb_gray_average_3x3_line_filter.sv
